### src/pes_pkg.sv
package pes_pkg;

    // register indexes on the configuration port
    localparam logic [2:0] CFG_MAX_SPEED = 3'd0;
    localparam logic [2:0] CFG_FORCE     = 3'd1;
    localparam logic [2:0] CFG_PAUSED    = 3'd2;
    localparam logic [2:0] CFG_WALL_MODE = 3'd3;
    localparam logic [2:0] CFG_BOX_SIZE  = 3'd4;

    // wall modes (code 3 acts as no wall)
    localparam logic [1:0] WALL_NONE   = 2'd0;
    localparam logic [1:0] WALL_BOUNCE = 2'd1;
    localparam logic [1:0] WALL_CYCLIC = 2'd2;

    // reset values
    localparam logic [30:0] MAX_SPEED_RST = 31'd262144;
    localparam logic [15:0] BOX_SIZE_RST  = 16'd512;

    // pipeline layout
    localparam int NSQ    = 32;               // one root bit per stage
    localparam int NDV    = 31;               // one quotient bit per stage
    localparam int S_SQ0  = 3;
    localparam int S_DV0  = S_SQ0 + NSQ;
    localparam int S_FIN  = S_DV0 + NDV;
    localparam int S_WALL = S_FIN + 1;
    localparam int NSTG   = S_WALL + 1;

    typedef struct packed {
        logic              act;     // not paused
        logic              scale;   // rescale velocity to max speed
        logic [2:0][31:0]  p;
        logic [2:0][31:0]  v;
        logic [2:0][63:0]  sq;      // squared components
        logic [61:0]       msq;     // max speed squared
        logic [2:0][61:0]  rem;     // |v| * max_speed, then division remainder
        logic [2:0][30:0]  q;       // quotients
        logic [63:0]       n;       // root remainder
        logic [63:0]       res;     // root
    } t_pipe;

    function automatic logic [31:0] sat32(input logic signed [32:0] x);
        logic [31:0] r;
        if (x > 33'sd2147483647)       r = 32'h7FFF_FFFF;
        else if (x < -33'sd2147483648) r = 32'h8000_0000;
        else                           r = x[31:0];
        return r;
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] x);
        return x[31] ? (~x + 32'd1) : x;
    endfunction

endpackage

### src/particle_euler_step_with_walls.sv
// Euler step for one particle per beat: velocity += acceleration (saturating),
// optional rescale of velocity to max speed (bit-serial square root, then one
// restoring divider lane per axis), position += velocity, then the box wall
// rule. A fully pipelined datapath: one particle enters every cycle while the
// output is not stalled; the 68 register stages are mostly the 32 root stages
// and the 31 quotient stages. A stalled output freezes the whole pipe.
module particle_euler_step_with_walls
    import pes_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    input  logic [31:0] i_acc_x,
    input  logic [31:0] i_acc_y,
    input  logic [31:0] i_acc_z,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_new_pos_x,
    output logic [31:0] o_new_pos_y,
    output logic [31:0] o_new_pos_z,
    output logic [31:0] o_new_vel_x,
    output logic [31:0] o_new_vel_y,
    output logic [31:0] o_new_vel_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int WW = 16 + FRAC_BITS + 2;   // wall limit width, signed

    logic [30:0] r_max_speed;
    logic        r_force;
    logic        r_paused;
    logic [1:0]  r_wall_mode;
    logic [15:0] r_box_size;

    t_pipe r_pipe [NSTG];
    t_pipe n_pipe [NSTG];
    logic  r_vld  [NSTG];
    logic  adv;

    assign adv         = !r_vld[NSTG-1] || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_vld[NSTG-1];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_speed <= MAX_SPEED_RST;
            r_force     <= 1'b1;
            r_paused    <= 1'b1;
            r_wall_mode <= WALL_CYCLIC;
            r_box_size  <= BOX_SIZE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_SPEED: r_max_speed <= i_cfg_data[30:0];
                CFG_FORCE:     r_force     <= i_cfg_data[0];
                CFG_PAUSED:    r_paused    <= i_cfg_data[0];
                CFG_WALL_MODE: r_wall_mode <= i_cfg_data[1:0];
                CFG_BOX_SIZE:  r_box_size  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // stage 0: velocity sum
    always_comb begin
        logic [2:0][31:0] pi, vi, ai;
        pi = {i_pos_z, i_pos_y, i_pos_x};
        vi = {i_vel_z, i_vel_y, i_vel_x};
        ai = {i_acc_z, i_acc_y, i_acc_x};
        n_pipe[0]     = '0;
        n_pipe[0].act = !r_paused;
        n_pipe[0].p   = pi;
        for (int i = 0; i < 3; i++) begin
            n_pipe[0].v[i] = r_paused ? vi[i]
                : sat32(33'(signed'(vi[i])) + 33'(signed'(ai[i])));
        end
    end

    // stage 1: squares and scaled magnitudes
    always_comb begin
        logic [31:0] m;
        n_pipe[1]     = r_pipe[0];
        n_pipe[1].msq = 62'(r_max_speed) * 62'(r_max_speed);
        for (int i = 0; i < 3; i++) begin
            m = mag32(r_pipe[0].v[i]);
            n_pipe[1].sq[i]  = 64'(m) * 64'(m);
            n_pipe[1].rem[i] = 62'(64'(m) * 64'(r_max_speed));
        end
    end

    // stage 2: sum of squares and speed test
    always_comb begin
        logic [63:0] ss;
        ss = r_pipe[1].sq[0] + r_pipe[1].sq[1] + r_pipe[1].sq[2];
        n_pipe[2]       = r_pipe[1];
        n_pipe[2].n     = ss;
        n_pipe[2].res   = '0;
        n_pipe[2].q     = '0;
        n_pipe[2].scale = r_pipe[1].act && (ss > 64'(r_pipe[1].msq) || r_force);
    end

    // square root stages, two radicand bits each
    for (genvar j = 0; j < NSQ; j++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'(1) << (62 - 2 * j);
        always_comb begin
            logic [63:0] t;
            t = r_pipe[S_SQ0+j-1].res + BIT;
            n_pipe[S_SQ0+j] = r_pipe[S_SQ0+j-1];
            if (r_pipe[S_SQ0+j-1].n >= t) begin
                n_pipe[S_SQ0+j].n   = r_pipe[S_SQ0+j-1].n - t;
                n_pipe[S_SQ0+j].res = (r_pipe[S_SQ0+j-1].res >> 1) + BIT;
            end else begin
                n_pipe[S_SQ0+j].res = r_pipe[S_SQ0+j-1].res >> 1;
            end
        end
    end

    // restoring divide stages, one quotient bit per lane each
    for (genvar t = 0; t < NDV; t++) begin : g_div
        localparam int K = NDV - 1 - t;
        always_comb begin
            logic [63:0] d;
            d = 64'(r_pipe[S_DV0+t-1].res[31:0]) << K;
            n_pipe[S_DV0+t] = r_pipe[S_DV0+t-1];
            for (int i = 0; i < 3; i++) begin
                if (64'(r_pipe[S_DV0+t-1].rem[i]) >= d) begin
                    n_pipe[S_DV0+t].rem[i]  = 62'(64'(r_pipe[S_DV0+t-1].rem[i]) - d);
                    n_pipe[S_DV0+t].q[i][K] = 1'b1;
                end
            end
        end
    end

    // final velocity and position update
    always_comb begin
        t_pipe s;
        s = r_pipe[S_FIN-1];
        n_pipe[S_FIN] = s;
        for (int i = 0; i < 3; i++) begin
            if (s.scale) begin
                if (s.res[31:0] == 32'd0)
                    n_pipe[S_FIN].v[i] = '0;
                else if (s.v[i][31])
                    n_pipe[S_FIN].v[i] = 32'd0 - {1'b0, s.q[i]};
                else
                    n_pipe[S_FIN].v[i] = {1'b0, s.q[i]};
            end
        end
        for (int i = 0; i < 3; i++) begin
            if (s.act)
                n_pipe[S_FIN].p[i] = sat32(33'(signed'(s.p[i]))
                                           + 33'(signed'(n_pipe[S_FIN].v[i])));
        end
    end

    // wall rule
    always_comb begin
        t_pipe s;
        logic signed [WW-1:0] half, wall, pw;
        s    = r_pipe[S_WALL-1];
        half = signed'(WW'(r_box_size >> 1) << FRAC_BITS);
        wall = signed'(WW'(r_box_size) << (FRAC_BITS - 1));
        n_pipe[S_WALL] = s;
        for (int i = 0; i < 3; i++) begin
            pw = WW'(signed'(s.p[i]));
            case (r_wall_mode)
                WALL_BOUNCE: begin
                    if (signed'(WW'(mag32(s.p[i]))) > half)
                        n_pipe[S_WALL].v[i] = sat32(-33'(signed'(s.v[i])));
                end
                WALL_CYCLIC: begin
                    if (pw > wall)
                        n_pipe[S_WALL].p[i] = (wall > WW'(2147483647)) ? 32'h8000_0000
                                              : 32'(-wall);
                    else if (pw < -wall)
                        n_pipe[S_WALL].p[i] = (wall > WW'(2147483647)) ? 32'h7FFF_FFFF
                                              : wall[31:0];
                end
                default: ;
            endcase
        end
    end

    // pipeline registers: valid bits travel with the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) r_vld[s] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= i_in_valid;
            for (int s = 1; s < NSTG; s++) r_vld[s] <= r_vld[s-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int s = 0; s < NSTG; s++) r_pipe[s] <= n_pipe[s];
        end
    end

    assign o_new_pos_x = r_pipe[NSTG-1].p[0];
    assign o_new_pos_y = r_pipe[NSTG-1].p[1];
    assign o_new_pos_z = r_pipe[NSTG-1].p[2];
    assign o_new_vel_x = r_pipe[NSTG-1].v[0];
    assign o_new_vel_y = r_pipe[NSTG-1].v[1];
    assign o_new_vel_z = r_pipe[NSTG-1].v[2];

endmodule

### tb/particle_step_checker.sv
module particle_step_checker
    import pes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [31:0] i_pos_x,
    input  logic [31:0] i_pos_y,
    input  logic [31:0] i_pos_z,
    input  logic [31:0] i_vel_x,
    input  logic [31:0] i_vel_y,
    input  logic [31:0] i_vel_z,
    input  logic [31:0] i_acc_x,
    input  logic [31:0] i_acc_y,
    input  logic [31:0] i_acc_z,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_new_pos_x,
    input  logic [31:0] i_new_pos_y,
    input  logic [31:0] i_new_pos_z,
    input  logic [31:0] i_new_vel_x,
    input  logic [31:0] i_new_vel_y,
    input  logic [31:0] i_new_vel_z,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic [31:0] o_pending,
    output logic [31:0] o_errors,
    output logic [31:0] o_checked
);

    typedef struct packed {
        logic [2:0][31:0] p;
        logic [2:0][31:0] v;
    } t_state6;

    // shadow copy of the register file
    logic [30:0] max_speed;
    logic        force_max;
    logic        paused;
    logic [1:0]  wall_mode;
    logic [15:0] box_size;

    t_state6     particle_q[$];
    logic [31:0] n_in;
    logic [31:0] n_out;
    logic [31:0] n_err;

    assign o_pending = n_in - n_out;
    assign o_errors  = n_err;
    assign o_checked = n_out;

    function automatic longint clamp_s32(input longint x);
        if (x > 64'sd2147483647) return 64'sd2147483647;
        if (x < -64'sd2147483648) return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned abs64(input longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // one Euler step plus wall rule at the current register settings
    function automatic t_state6 euler_step(input logic [2:0][31:0] pin,
                                           input logic [2:0][31:0] vin,
                                           input logic [2:0][31:0] ain);
        longint p[3];
        longint v[3];
        longint unsigned ss;
        longint unsigned len;
        longint unsigned qv;
        longint unsigned ms;
        longint lim;
        t_state6 r;
        ms = longint'(max_speed);
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'($signed(pin[i]));
            v[i] = longint'($signed(vin[i]));
        end
        if (!paused) begin
            ss = 0;
            for (int i = 0; i < 3; i++) begin
                v[i] = clamp_s32(v[i] + longint'($signed(ain[i])));
                ss = ss + abs64(v[i]) * abs64(v[i]);
            end
            if (ss > ms * ms || force_max) begin
                len = floor_sqrt(ss);
                for (int i = 0; i < 3; i++) begin
                    if (len == 0) begin
                        v[i] = 0;
                    end else begin
                        qv = abs64(v[i]) * ms / len;
                        v[i] = (v[i] < 0) ? -longint'(qv) : longint'(qv);
                    end
                end
            end
            for (int i = 0; i < 3; i++) p[i] = clamp_s32(p[i] + v[i]);
        end
        if (wall_mode == WALL_BOUNCE) begin
            lim = longint'(box_size >> 1) << 16;
            for (int i = 0; i < 3; i++)
                if (longint'(abs64(p[i])) > lim) v[i] = clamp_s32(-v[i]);
        end else if (wall_mode == WALL_CYCLIC) begin
            lim = longint'(box_size) << 15;
            for (int i = 0; i < 3; i++) begin
                if (p[i] > lim) p[i] = clamp_s32(-lim);
                else if (p[i] < -lim) p[i] = clamp_s32(lim);
            end
        end
        for (int i = 0; i < 3; i++) begin
            r.p[i] = p[i][31:0];
            r.v[i] = v[i][31:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH beat %0d %s: got %h expected %h", n_out, what, got, want);
        n_err = n_err + 1;
    endtask

    // watch the three channels at each rising edge
    always @(posedge i_clk) begin
        t_state6 want;
        t_state6 got;
        if (!i_rst_n) begin
            max_speed = MAX_SPEED_RST;
            force_max = 1'b1;
            paused    = 1'b1;
            wall_mode = WALL_CYCLIC;
            box_size  = BOX_SIZE_RST;
            n_in  = 0;
            n_out = 0;
            n_err = 0;
            particle_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.p = {i_new_pos_z, i_new_pos_y, i_new_pos_x};
                got.v = {i_new_vel_z, i_new_vel_y, i_new_vel_x};
                if (particle_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected, new_pos[0]",
                                    got.p[0], 32'h0);
                end else begin
                    want = particle_q.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        if (got.p[i] !== want.p[i])
                            report_mismatch($sformatf("new_pos[%0d]", i), got.p[i], want.p[i]);
                        if (got.v[i] !== want.v[i])
                            report_mismatch($sformatf("new_vel[%0d]", i), got.v[i], want.v[i]);
                    end
                end
                n_out = n_out + 1;
            end
            if (i_in_valid && i_in_ready) begin
                particle_q.push_back(euler_step({i_pos_z, i_pos_y, i_pos_x},
                                                {i_vel_z, i_vel_y, i_vel_x},
                                                {i_acc_z, i_acc_y, i_acc_x}));
                n_in = n_in + 1;
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_SPEED: max_speed = i_cfg_data[30:0];
                    CFG_FORCE:     force_max = i_cfg_data[0];
                    CFG_PAUSED:    paused    = i_cfg_data[0];
                    CFG_WALL_MODE: wall_mode = i_cfg_data[1:0];
                    CFG_BOX_SIZE:  box_size  = i_cfg_data[15:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

### tb/tb_particle_euler_step_with_walls.sv
module tb_particle_euler_step_with_walls;
    import pes_pkg::*;

    localparam logic [2:0] CFG_SPARE = 3'd7;  // no register behind it
    localparam logic [1:0] WALL_SPARE = 2'd3; // unused wall code, acts as no wall
    localparam int DRAIN_CYCLES = 100;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [31:0] i_pos_x, i_pos_y, i_pos_z;
    logic [31:0] i_vel_x, i_vel_y, i_vel_z;
    logic [31:0] i_acc_x, i_acc_y, i_acc_z;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [31:0] o_new_pos_x, o_new_pos_y, o_new_pos_z;
    logic [31:0] o_new_vel_x, o_new_vel_y, o_new_vel_z;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic [31:0] pending, errors, checked;

    int idle_pct;
    int stall_pct;
    int idle_cnt;

    particle_euler_step_with_walls dut (.*);

    particle_step_checker checker_i (
        .i_clk, .i_rst_n,
        .i_in_valid, .i_in_ready(o_in_ready),
        .i_pos_x, .i_pos_y, .i_pos_z, .i_vel_x, .i_vel_y, .i_vel_z,
        .i_acc_x, .i_acc_y, .i_acc_z,
        .i_out_valid(o_out_valid), .i_out_ready,
        .i_new_pos_x(o_new_pos_x), .i_new_pos_y(o_new_pos_y), .i_new_pos_z(o_new_pos_z),
        .i_new_vel_x(o_new_vel_x), .i_new_vel_y(o_new_vel_y), .i_new_vel_z(o_new_vel_z),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_pending(pending), .o_errors(errors), .o_checked(checked)
    );

    always begin
        i_clk = 1'b1; #4;
        i_clk = 1'b0; #4;
    end

    // receiver back-pressure
    always @(negedge i_clk) i_out_ready <= ($urandom_range(99) >= stall_pct);

    // watchdog on cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            idle_cnt <= 0;
        else if (idle_cnt >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired");
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else
            idle_cnt <= idle_cnt + 1;
    end

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic set_regs(input logic [31:0] ms, input logic [31:0] frc,
                            input logic [31:0] pz, input logic [31:0] wm,
                            input logic [31:0] bx);
        wait_drained();
        cfg_write(CFG_MAX_SPEED, ms);
        cfg_write(CFG_FORCE, frc);
        cfg_write(CFG_PAUSED, pz);
        cfg_write(CFG_WALL_MODE, wm);
        cfg_write(CFG_BOX_SIZE, bx);
    endtask

    // one particle beat, with random idle cycles ahead of it
    task automatic send_particle(input logic [31:0] px, input logic [31:0] py,
                                 input logic [31:0] pz, input logic [31:0] vx,
                                 input logic [31:0] vy, input logic [31:0] vz,
                                 input logic [31:0] ax, input logic [31:0] ay,
                                 input logic [31:0] az);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pos_x <= px; i_pos_y <= py; i_pos_z <= pz;
        i_vel_x <= vx; i_vel_y <= vy; i_vel_z <= vz;
        i_acc_x <= ax; i_acc_y <= ay; i_acc_z <= az;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // mixed value shapes: full range, small, extremes, near the box wall
    function automatic logic [31:0] pick_val(input int wall_units);
        logic [31:0] r;
        int sel;
        sel = $urandom_range(9);
        if (sel < 2)
            r = $urandom;
        else if (sel < 6)
            r = $urandom_range(32'h0008_0000) - 32'h0004_0000;
        else if (sel < 7)
            case ($urandom_range(4))
                0: r = 32'h8000_0000;
                1: r = 32'h7FFF_FFFF;
                2: r = 32'h0;
                3: r = 32'hFFFF_FFFF;
                default: r = 32'h0000_0001;
            endcase
        else begin
            r = (wall_units << 15) + $urandom_range(32'h0002_0000) - 32'h0001_0000;
            if ($urandom_range(1)) r = -r;
        end
        return r;
    endfunction

    task automatic random_particle(input int wall_units);
        send_particle(pick_val(wall_units), pick_val(wall_units), pick_val(wall_units),
                      pick_val(wall_units), pick_val(wall_units), pick_val(wall_units),
                      pick_val(wall_units), pick_val(wall_units), pick_val(wall_units));
    endtask

    initial begin
        logic [31:0] ms, bx, wm;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        {i_pos_x, i_pos_y, i_pos_z, i_vel_x, i_vel_y, i_vel_z} = '0;
        {i_acc_x, i_acc_y, i_acc_z} = '0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset settings are paused with cyclic wall
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h0100_0001, 1, 2, 3, 4, 5, 6);
        send_particle(32'h0100_0000, 32'hFF00_0000, 32'h00FF_FFFF, 0, 0, 0, 0, 0, 0);
        end_burst();
        // running, forced rescale, zero velocity and extremes
        set_regs(32'h0004_0000, 1, 0, 32'(WALL_NONE), 512);
        send_particle(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_particle(5, 6, 7, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0);
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 0, 32'h7FFF_FFFF, 32'h8000_0000,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        end_burst();
        // clamp only when too fast, largest max speed, bouncing
        set_regs(32'hFFFF_FFFF, 0, 0, 32'(WALL_BOUNCE), 32'hFFFF_0001);
        send_particle(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 0);
        send_particle(32'h7FFF_0000, 32'h8000_0000, 3, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 1, 1, 1);
        end_burst();
        set_regs(32'h0001_0000, 0, 0, 32'(WALL_BOUNCE), 1);
        send_particle(32'h0000_0001, 32'hFFFF_FFFF, 0, 32'h8000_0000, 0, 0, 0, 0, 0);
        send_particle(32'h0000_8000, 32'h0001_0000, 32'hFFFF_0000, 3, 32'h0003_0000, 0, 0, 0, 0);
        end_burst();
        // zero max speed, cyclic with box 0 and the largest box
        set_regs(0, 0, 0, 32'(WALL_CYCLIC), 0);
        send_particle(1, 32'hFFFF_FFFF, 0, 32'h0001_0000, 0, 0, 0, 0, 0);
        send_particle(0, 0, 0, 0, 0, 0, 0, 0, 0);
        end_burst();
        set_regs(32'h0010_0000, 0, 1, 32'(WALL_CYCLIC), 32'h0000_FFFF);
        send_particle(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_8000, 9, 9, 9, 9, 9, 9);
        end_burst();
        set_regs(32'h0010_0000, 0, 0, 32'(WALL_SPARE), 32768);
        cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
        send_particle(32'h4000_0000, 32'hC000_0000, 32'h4000_0000, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h0000_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_particle(32'h4000_0001, 32'hC000_0000, 0, 0, 0, 0, 0, 0, 0);
        end_burst();

        // random phases over settings and idling patterns
        for (int ph = 0; ph < 9; ph++) begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 81; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 13; stall_pct = 13; end
            endcase
            case (ph % 3)
                0: ms = $urandom_range(32'h0020_0000);
                1: ms = $urandom;
                default: ms = (ph == 2) ? 32'h7FFF_FFFF : 0;
            endcase
            bx = (ph == 4) ? 32'h0000_FFFF : ((ph == 7) ? 1 : $urandom_range(1, 32768));
            bx = bx | ($urandom & 32'hFFFF_0000);
            wm = (ph == 8) ? 32'(WALL_NONE) : 32'(ph % 4);
            set_regs(ms, $urandom, (ph == 5) ? 1 : 0, wm | ($urandom & 32'hFFFF_FFFC), bx);
            for (int k = 0; k < 150; k++) begin
                random_particle(int'(bx[15:0]));
                if (ph == 3 && k == 75) begin
                    end_burst();
                    wait_drained();
                end
            end
            end_burst();
        end

        // drain
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Covered %0d particles over all wall modes, paused and running,", checked);
        $display("forced and threshold speed clamps, with mixed idle and stall patterns.");
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
